>>> src/twc_pkg.sv
package twc_pkg;

  localparam int TEX_W = 64;
  localparam int TEX_H = 64;

  localparam int ADDR_W  = 12;
  localparam int TEXEL_W = 24;
  localparam int COORD_W = 12;
  localparam int LH_W    = 20;
  localparam int SH_W    = 13;
  localparam int POS_W   = 40;

  localparam int COL_W = $clog2(TEX_W);
  localparam int ROW_W = $clog2(TEX_H);

  localparam int DIV_W = $clog2(TEX_H + 1) + 16;
  localparam int REM_W = LH_W + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TEX_H * 65536);

  localparam int MAG_W   = 17;
  localparam int NUM2_W  = 22;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = DIV_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [SH_W-1:0]    SH_RESET  = SH_W'(720);
  localparam logic [TEXEL_W-1:0] SIDE_MASK = TEXEL_W'(8355711);

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_COL  = 2'd1;
  localparam logic [1:0] REQ_PIX  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [11:0]        texel_addr;
    logic [23:0]        texel_color;
    logic [11:0]        screen_col;
    logic [11:0]        line_top;
    logic [11:0]        line_bottom;
    logic [19:0]        proj_height;
    logic               hit_side;
    logic signed [31:0] hit_pos;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [31:0]        perp_dist;
  } twc_req_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] pixel_color;
    logic        last_pixel;
  } twc_pix_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } twc_div_stat_t;

endpackage

>>> src/twc_ram.sv
module twc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/twc_mul.sv
module twc_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [twc_pkg::MUL_A_W-1:0]   a,
  input  logic signed [twc_pkg::MUL_B_W-1:0]   b,
  output logic signed [twc_pkg::MUL_P_W-1:0]   p
);
  import twc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

>>> src/twc_div.sv
module twc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [twc_pkg::LH_W-1:0]    divisor,
  output twc_pkg::twc_div_stat_t      stat
);
  import twc_pkg::*;

  logic [DIV_W-1:0] num;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [REM_W-1:0] rem_sh;
  logic             fits;

  assign rem_sh = {rem[REM_W-2:0], num[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  assign stat.done = done;
  assign stat.quot = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DIV_W);
        num <= DIVIDEND;
        rem <= '0;
      end else if (cnt != '0) begin
        num <= {num[DIV_W-2:0], fits};
        rem <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/textured_wall_column.sv
// Textured wall column unit. A load beat writes one texel and stays ready. A
// pixel beat reads the texture RAM (registered read) into the output register;
// the pixel waits in the output register while the next request is taken. A
// column-start beat runs ST_MUL_DIST, ST_COL, ST_DIV, ST_MUL_POS and ST_POS:
// one shared multiplier forms the wall offset and later the start position,
// and a restoring divider produces the texture step one quotient bit per
// cycle, DIV_W = clog2(TEX_H + 1) + 16 bits. The texture RAM has no reset;
// read only texels that were loaded. The user writes screen_height through
// cfg_we / cfg_wdata only while no request is in flight; it is not enforced.
module textured_wall_column (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  twc_pkg::twc_req_t     req,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output twc_pkg::twc_pix_t     pix,
  input  logic                  cfg_we,
  input  logic [twc_pkg::SH_W-1:0] cfg_wdata
);
  import twc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_DIST, ST_COL, ST_DIV, ST_MUL_POS, ST_POS, ST_PIX
  } state_t;

  state_t state;

  logic [SH_W-1:0]    screen_height;
  logic [COL_W-1:0]   tex_column;
  logic [POS_W-1:0]   tex_position;
  logic [DIV_W-1:0]   tex_step;
  logic [COORD_W-1:0] current_row;
  logic [COORD_W-1:0] bottom_row;
  logic [COORD_W-1:0] strip_column;
  logic               strip_side;
  logic               strip_active;

  logic [15:0]        cap_pos;
  logic [31:0]        cap_dist;
  logic [MAG_W-1:0]   cap_mag;
  logic               cap_neg;
  logic               cap_mirror;
  logic [LH_W-1:0]    cap_lh;
  logic [COORD_W-1:0] cap_top;

  logic accept;
  logic signed [15:0] dir_sel;
  logic [MAG_W-1:0]   dir_mag;
  logic               dir_mirror;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [NUM2_W-1:0]  num2;

  logic [29:0]          prod_lo;
  logic [15:0]          frac;
  logic [16+COL_W-1:0]  frac_scaled;
  logic [COL_W-1:0]     tx;

  logic                div_start;
  twc_div_stat_t       div_stat;

  logic [ROW_W-1:0]    row_int;
  logic [ROW_W-1:0]    row;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;
  logic                wr_en;
  logic [TEXEL_W-1:0]  texel;
  logic [TEXEL_W-1:0]  color;
  logic                last;
  logic                pix_load;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  assign dir_sel    = req.hit_side ? req.dir_x : req.dir_y;
  assign dir_mag    = dir_sel[15] ? (MAG_W'(0) - {dir_sel[15], dir_sel})
                                  : {1'b0, dir_sel};
  assign dir_mirror = req.hit_side ? req.dir_y[15]
                                   : (!req.dir_x[15] && (req.dir_x != '0));

  assign num2 = $signed({(NUM2_W-COORD_W-1)'(0), cap_top, 1'b0})
              - $signed({(NUM2_W-SH_W)'(0), screen_height})
              + $signed({(NUM2_W-LH_W)'(0), cap_lh});

  always_comb begin
    mul_en = 1'b0;
    mul_a  = $signed({1'b0, cap_dist});
    mul_b  = $signed({(MUL_B_W-MAG_W)'(0), cap_mag});
    unique case (state)
      ST_MUL_DIST: mul_en = 1'b1;
      ST_MUL_POS: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(num2);
        mul_b  = $signed({1'b0, tex_step});
      end
      default: mul_en = 1'b0;
    endcase
  end

  twc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign prod_lo     = cap_neg ? (30'(0) - mul_p[29:0]) : mul_p[29:0];
  assign frac        = cap_pos + prod_lo[29:14];
  assign frac_scaled = (16+COL_W)'(frac) * (16+COL_W)'(TEX_W);
  assign tx          = cap_mirror ? (COL_W'(TEX_W - 1) - frac_scaled[16 +: COL_W])
                                  : frac_scaled[16 +: COL_W];

  assign div_start = (state == ST_COL);

  twc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (cap_lh),
    .stat    (div_stat)
  );

  assign row_int = tex_position[16 +: ROW_W]
                 + ROW_W'(tex_position[POS_W-1] && (tex_position[15:0] != '0));
  assign row     = row_int & ROW_W'(TEX_H - 1);
  assign rd_addr = ADDR_W'(32'(row) * 32'(TEX_W) + 32'(tex_column));
  assign rd_en   = accept && (req.req_type == REQ_PIX) && strip_active;
  assign wr_en   = accept && (req.req_type == REQ_LOAD);

  twc_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (1 << ADDR_W)
  ) u_tex (
    .clk   (clk),
    .we    (wr_en),
    .waddr (req.texel_addr),
    .wdata (req.texel_color),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (texel)
  );

  assign color    = strip_side ? ({1'b0, texel[TEXEL_W-1:1]} & SIDE_MASK) : texel;
  assign last     = current_row >= bottom_row;
  assign pix_load = (state == ST_PIX) && (!pix_valid || pix_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      screen_height <= SH_RESET;
      tex_column    <= '0;
      tex_position  <= '0;
      tex_step      <= '0;
      current_row   <= '0;
      bottom_row    <= '0;
      strip_column  <= '0;
      strip_side    <= 1'b0;
      strip_active  <= 1'b0;
      pix_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        screen_height <= cfg_wdata;
      end
      if (pix_load) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req.req_type)
              REQ_COL: begin
                cap_pos      <= req.hit_pos[15:0];
                cap_dist     <= req.perp_dist;
                cap_mag      <= dir_mag;
                cap_neg      <= dir_sel[15];
                cap_mirror   <= dir_mirror;
                cap_lh       <= (req.proj_height == '0) ? LH_W'(1) : req.proj_height;
                cap_top      <= req.line_top;
                current_row  <= req.line_top;
                bottom_row   <= req.line_bottom;
                strip_column <= req.screen_col;
                strip_side   <= req.hit_side;
                strip_active <= req.line_top <= req.line_bottom;
                state        <= ST_MUL_DIST;
              end
              REQ_PIX: begin
                if (strip_active) begin
                  state <= ST_PIX;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_MUL_DIST: state <= ST_COL;
        ST_COL: begin
          tex_column <= tx;
          state      <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            tex_step <= div_stat.quot;
            state    <= ST_MUL_POS;
          end
        end
        ST_MUL_POS: state <= ST_POS;
        ST_POS: begin
          tex_position <= mul_p[POS_W:1];
          state        <= ST_IDLE;
        end
        ST_PIX: begin
          if (pix_load) begin
            pix.pixel_x     <= strip_column;
            pix.pixel_y     <= current_row;
            pix.pixel_color <= color;
            pix.last_pixel  <= last;
            tex_position    <= tex_position + POS_W'(tex_step);
            if (last) begin
              strip_active <= 1'b0;
            end else begin
              current_row <= current_row + COORD_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/twc_checker.sv
module twc_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input twc_pkg::twc_req_t req,
  input logic              pix_valid,
  input logic              pix_ready,
  input twc_pkg::twc_pix_t pix
);
  import twc_pkg::*;

  logic req_beat;
  assign req_beat = req_valid && req_ready;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix))
    else $error("stalled pixel beat changed");

  a_pixel_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(req_beat && (req.req_type == REQ_PIX), 2))
    else $error("pixel without a pixel request two cycles earlier");

  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    req_beat && (req.req_type == REQ_LOAD) |=> req_ready)
    else $error("load beat stalled the request channel");

  a_col_busy: assert property (@(posedge clk) disable iff (rst)
    req_beat && (req.req_type == REQ_COL) |=> !req_ready)
    else $error("column start did not occupy the unit");

endmodule

bind textured_wall_column twc_checker u_checker (.*);
